// ===== rtl/core/spq_pkg.sv =====
// spq_pkg: shared constants and codes for the stable priority queue
`default_nettype none

package spq_pkg;

  // parameter defaults
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned PRIO_BITS_DEF = 16;
  localparam int unsigned TAG_BITS_DEF  = 16;

  // word field widths on the ports
  localparam int unsigned PRIO_W      = 16;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = PRIO_W + TAG_W;
  localparam int unsigned OUT_FIELD_W = TAG_W + PRIO_W + CNT_W + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

endpackage

`default_nettype wire

// ===== rtl/core/spq_ram.sv =====
// spq_ram: generic single-write single-read ram with registered read data
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/stable_priority_queue.sv =====
// stable_priority_queue: sorted-list priority queue kept in one ram, stable on ties
//
//  channel  | dir | tuser          | tdata
//  ---------+-----+----------------+------------------------------------------------
//  s_axis   | in  | mode           | entry_priority, entry_tag
//  m_axis   | out | status         | removed_tag, head_priority, entry_count, empty
//
// one word at a time: an enqueue walks down from the tail and moves each stored entry with
// a larger priority up one slot before the new entry is written; a dequeue shifts every
// remaining entry down one slot; a dropped enqueue, an enqueue into an empty queue and a
// dequeue on an empty queue go straight to S_FIN; one ram read and write per cycle.
// the input is ready only while idle, so a new word is taken the cycle after S_FIN.
// reset clears count and control; ram contents stay undefined, no clearing pass.
// a finished word waits in S_FIN while the output register still holds an unaccepted
// word; m_axis_tready low holds that word and the sequencer.
`default_nettype none

module stable_priority_queue #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  parameter int unsigned TAG_BITS  = spq_pkg::TAG_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] entry_priority, [31:16] entry_tag
  input  wire logic [spq_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [0] mode
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [15:0] removed_tag, [31:16] head_priority, [36:32] entry_count, [37] queue_empty
  output logic [spq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [spq_pkg::STATUS_W-1:0]        m_axis_tuser
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = PRIO_BITS + TAG_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_INS0,
    S_DEQ,
    S_FIN
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           count_q;
  logic [PRIO_BITS-1:0]    head_prio_q;
  logic [TAG_BITS-1:0]     head_tag_q;
  logic [PRIO_BITS-1:0]    prio_q;
  logic [TAG_BITS-1:0]     tag_q;
  logic [AW-1:0]           idx_q;
  spq_pkg::status_e        status_q;
  logic [TAG_BITS-1:0]     removed_q;

  logic                    m_tvalid_q;
  logic [spq_pkg::STATUS_W-1:0]    m_tuser_q;
  logic [spq_pkg::OUT_TDATA_W-1:0] m_tdata_q;

  logic [PRIO_BITS-1:0]    in_prio;
  logic [TAG_BITS-1:0]     in_tag;
  logic                    accept;
  logic                    out_free;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_rdata;
  logic [PRIO_BITS-1:0]    rd_prio;
  logic [TAG_BITS-1:0]     rd_tag;

  logic [spq_pkg::PRIO_W-1:0] out_head;
  logic [spq_pkg::TAG_W-1:0]  out_removed;
  logic [spq_pkg::CNT_W-1:0]  out_count;
  logic                       out_empty;

  assign in_prio = PRIO_BITS'({{PRIO_BITS{1'b0}}, s_axis_tdata[spq_pkg::PRIO_W-1:0]});
  assign in_tag  = TAG_BITS'({{TAG_BITS{1'b0}},
                              s_axis_tdata[spq_pkg::IN_TDATA_W-1:spq_pkg::PRIO_W]});

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;

  assign rd_prio = ram_rdata[EW-1:TAG_BITS];
  assign rd_tag  = ram_rdata[TAG_BITS-1:0];

  // enqueue walks down from the tail, read of the next slot issued speculatively;
  // dequeue walks up from slot 1, shifting each entry down by one
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {prio_q, tag_q};
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == spq_pkg::MODE_ENQ) begin
            if (count_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = {in_prio, in_tag};
            end else if (count_q != CW'(DEPTH)) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(count_q - CW'(1));
            end
          end else if (count_q > CW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(1);
          end
        end
      end
      S_ENQ: begin
        ram_we = 1'b1;
        if (rd_prio > prio_q) begin
          ram_wdata = ram_rdata;
          if (idx_q > AW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = idx_q - AW'(2);
          end
        end
      end
      S_INS0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
      end
      S_DEQ: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - AW'(1);
        ram_wdata = ram_rdata;
        if (CW'(idx_q) + CW'(1) < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  assign out_empty   = (count_q == '0);
  assign out_head    = out_empty ? '0 :
                       spq_pkg::PRIO_W'({{spq_pkg::PRIO_W{1'b0}}, head_prio_q});
  assign out_removed = spq_pkg::TAG_W'({{spq_pkg::TAG_W{1'b0}}, removed_q});
  assign out_count   = spq_pkg::CNT_W'({{spq_pkg::CNT_W{1'b0}}, count_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      m_tvalid_q  <= 1'b0;
      idx_q       <= '0;
      status_q    <= spq_pkg::ST_OK;
      head_prio_q <= '0;
      head_tag_q  <= '0;
    end else begin
      // S_FIN reloads the register itself when it frees up
      if (m_tvalid_q && m_axis_tready && state_q != S_FIN) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            removed_q <= '0;
            status_q  <= spq_pkg::ST_OK;
            prio_q    <= in_prio;
            tag_q     <= in_tag;
            if (s_axis_tuser == spq_pkg::MODE_ENQ) begin
              if (count_q == CW'(DEPTH)) begin
                status_q <= spq_pkg::ST_FULL;
                state_q  <= S_FIN;
              end else if (count_q == '0) begin
                head_prio_q <= in_prio;
                head_tag_q  <= in_tag;
                count_q     <= CW'(1);
                state_q     <= S_FIN;
              end else begin
                idx_q   <= AW'(count_q);
                state_q <= S_ENQ;
              end
            end else begin
              if (count_q == '0) begin
                status_q <= spq_pkg::ST_EMPTY;
                state_q  <= S_FIN;
              end else begin
                removed_q <= head_tag_q;
                if (count_q == CW'(1)) begin
                  count_q <= '0;
                  state_q <= S_FIN;
                end else begin
                  idx_q   <= AW'(1);
                  state_q <= S_DEQ;
                end
              end
            end
          end
        end
        S_ENQ: begin
          if (rd_prio > prio_q) begin
            idx_q <= idx_q - AW'(1);
            if (idx_q == AW'(1)) begin
              state_q <= S_INS0;
            end
          end else begin
            count_q <= count_q + CW'(1);
            state_q <= S_FIN;
          end
        end
        S_INS0: begin
          // new entry lands at the head
          head_prio_q <= prio_q;
          head_tag_q  <= tag_q;
          count_q     <= count_q + CW'(1);
          state_q     <= S_FIN;
        end
        S_DEQ: begin
          if (idx_q == AW'(1)) begin
            head_prio_q <= rd_prio;
            head_tag_q  <= rd_tag;
          end
          idx_q <= idx_q + AW'(1);
          if (CW'(idx_q) + CW'(1) == count_q) begin
            count_q <= count_q - CW'(1);
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tuser_q  <= status_q;
            m_tdata_q  <= spq_pkg::OUT_TDATA_W'({out_empty, out_count, out_head, out_removed});
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tuser  = m_tuser_q;
  assign m_axis_tdata  = m_tdata_q;

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // count never runs past the ram depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // a shift step never writes the slot it reads in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("ram read and write hit the same slot");

  // the insert walk never sits at slot zero
  a_enq_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENQ) |-> (idx_q != '0))
    else $error("insert walk reached slot zero");

  // a dropped enqueue reports a full queue in its word
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_tuser_q == spq_pkg::ST_FULL) |->
      (m_tdata_q[spq_pkg::TAG_W+spq_pkg::PRIO_W +: spq_pkg::CNT_W] ==
       spq_pkg::CNT_W'(DEPTH)))
    else $error("full status with room left");

  // an empty-dequeue word reports an empty queue
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && m_tuser_q == spq_pkg::ST_EMPTY) |->
      m_tdata_q[spq_pkg::OUT_FIELD_W-1])
    else $error("empty status without empty flag");

endmodule

`default_nettype wire
